// ===== src/ncpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the rational B-spline point evaluator.
// No dependencies; imported by ncpe_div and nurbs_curve_point_eval.
package ncpe_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_DEGREE   = 7;
   localparam int DEF_KNOT_DEPTH   = 72;

   localparam int ACC_W = 40;
   localparam int NUM_W = ACC_W + 16;
   localparam int DEN_W = ACC_W;

   typedef enum logic [1:0] {
      F_KNOT   = 2'd0,
      F_VERTEX = 2'd1,
      F_EVAL   = 2'd2,
      F_NONE   = 2'd3
   } func_type;

   localparam logic CSR_DEGREE = 1'b0;
   localparam logic CSR_COUNT  = 1'b1;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic signed [NUM_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // round half up, then floor shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                    input int unsigned k);
      logic signed [63:0] half;
      half = 64'sd1 <<< (k - 1);
      return (x + half) >>> k;
   endfunction

endpackage

// ===== src/ncpe_div.sv =====
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on ncpe_pkg for widths and request/response types.
module ncpe_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ncpe_pkg::div_req_type req,
   output ncpe_pkg::div_rsp_type rsp
);
   import ncpe_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic               busy_ff, done_ff, neg_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   rem_ff, rem_in, dmag_ff;
   logic [DEN_W:0]     shifted, diff;
   logic               ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, dmag_ff};
      ge      = shifted >= {1'b0, dmag_ff};
      rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_in  = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
            dmag_ff <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
            neg_ff  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ===== src/nurbs_curve_point_eval.sv =====
`timescale 1ns / 1ps
// Rational B-spline curve point evaluator: tables, span search, basis
// recurrence and weighted sum under one sequencer. Uses ncpe_pkg, ncpe_div.
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser func, tdata slot..param_t
//  rsp      out  rsp_tvalid/tready    tuser zero_weight, tdata point xyz
//  csr      in   csr_we               csr_index, csr_wdata
//
// Write requests go into the tables as they are taken. An evaluate request
// runs span search, basis recurrence and weighted sum, with each divide on
// the 56-step shared divider. Ready is low while a point is in work and
// while a result waits; reset is synchronous, tables stay undefined until
// written.
module nurbs_curve_point_eval #(
   parameter int MAX_VERTICES = ncpe_pkg::DEF_MAX_VERTICES,
   parameter int MAX_DEGREE   = ncpe_pkg::DEF_MAX_DEGREE,
   parameter int KNOT_DEPTH   = ncpe_pkg::DEF_KNOT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // func
   // slot, knot_value, vertex_x, vertex_y, vertex_z, vertex_w, param_t, pad
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [0:0]   rsp_tuser,   // zero_weight
   output logic [95:0]  rsp_tdata,   // point_x, point_y, point_z
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [6:0]   csr_wdata
);
   import ncpe_pkg::*;

   localparam int IDX_W   = $clog2(MAX_VERTICES + 2 * MAX_DEGREE + KNOT_DEPTH + 130);
   localparam int KA_W    = $clog2(KNOT_DEPTH);
   localparam int VA_W    = $clog2(MAX_VERTICES);
   localparam int BI_W    = $clog2(MAX_DEGREE + 1);
   localparam int DEG_LIM = (MAX_DEGREE < MAX_VERTICES - 1) ? MAX_DEGREE : MAX_VERTICES - 1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_HI, ST_CHK_LO, ST_LO_CMP, ST_BS, ST_BS_CMP, ST_BAS_INIT,
      ST_LR, ST_LR2, ST_LR3, ST_DEN, ST_DIVW, ST_M1, ST_M2, ST_M3,
      ST_SA, ST_SB, ST_SC, ST_FIN, ST_FD, ST_FDW, ST_OUT
   } state_type;

   state_type          state_ff;
   logic [2:0]         degree_ff;
   logic [6:0]         count_ff;
   logic [IDX_W-1:0]   deg_ff, n_ff, span_ff, lo_ff, hi_ff, j_ff, r_ff;
   logic [1:0]         c_ff;
   logic signed [31:0] t_ff, saved_ff, tmp_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] bas_ff   [MAX_DEGREE+1];
   logic signed [31:0] left_ff  [MAX_DEGREE+1];
   logic signed [31:0] right_ff [MAX_DEGREE+1];
   logic signed [ACC_W-1:0] acc_ff [4];
   logic [VA_W-1:0]    va_ff;
   logic signed [31:0] px_ff [3];
   logic               zw_ff, rsp_valid_ff;
   div_req_type        div_req_ff;
   div_rsp_type        div_rsp;

   logic signed [31:0] knot_mem [KNOT_DEPTH];
   logic signed [31:0] vx_mem [MAX_VERTICES];
   logic signed [31:0] vy_mem [MAX_VERTICES];
   logic signed [31:0] vz_mem [MAX_VERTICES];
   logic signed [31:0] vw_mem [MAX_VERTICES];
   logic signed [31:0] kq_ff, vq_ff [4];
   logic               koob_ff;

   logic               accept;
   func_type           func;
   logic [IDX_W-1:0]   slot, ka, deg_c, vc_c, mid, li, ri;
   logic signed [31:0] kv, bas_r, bas_j;
   logic signed [DEN_W-1:0] den;
   logic signed [31:0] mul_a, mul_b;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign func       = func_type'(req_tuser);
   assign slot       = IDX_W'(req_tdata[6:0]);
   assign kv         = koob_ff ? 32'sd0 : kq_ff;
   assign mid        = (lo_ff + hi_ff) >> 1;
   assign li         = j_ff - r_ff;
   assign ri         = r_ff + 1'b1;
   assign bas_r      = bas_ff[r_ff[BI_W-1:0]];
   assign bas_j      = bas_ff[j_ff[BI_W-1:0]];
   assign den        = DEN_W'(right_ff[ri[BI_W-1:0]]) + DEN_W'(left_ff[li[BI_W-1:0]]);

   always_comb begin
      deg_c = IDX_W'(degree_ff);
      if (degree_ff == 3'd0) deg_c = IDX_W'(1);
      else if (deg_c > IDX_W'(DEG_LIM)) deg_c = IDX_W'(DEG_LIM);
      vc_c = IDX_W'(count_ff);
      if (vc_c > IDX_W'(MAX_VERTICES)) vc_c = IDX_W'(MAX_VERTICES);
      if (vc_c < deg_c + 1'b1) vc_c = deg_c + 1'b1;
   end

   always_comb begin
      unique case (state_ff)
         ST_HI:     ka = n_ff + 1'b1;
         ST_CHK_LO: ka = deg_ff;
         ST_BS:     ka = mid;
         ST_LR:     ka = span_ff + 1'b1 - j_ff;
         ST_LR2:    ka = span_ff + j_ff;
         default:   ka = '0;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_M1:   mul_a = right_ff[ri[BI_W-1:0]];
         ST_M2:   mul_a = left_ff[li[BI_W-1:0]];
         default: mul_a = bas_j;
      endcase
      unique case (state_ff)
         ST_M1, ST_M2: mul_b = tmp_ff;
         ST_SB:        mul_b = vq_ff[0];
         default:      mul_b = vq_ff[c_ff + 1'b1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && func == F_KNOT && slot < IDX_W'(KNOT_DEPTH))
         knot_mem[slot[KA_W-1:0]] <= $signed(req_tdata[38:7]);
      kq_ff   <= knot_mem[ka[KA_W-1:0]];
      koob_ff <= ka >= IDX_W'(KNOT_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (accept && func == F_VERTEX && slot < IDX_W'(MAX_VERTICES)) begin
         vx_mem[slot[VA_W-1:0]] <= $signed(req_tdata[70:39]);
         vy_mem[slot[VA_W-1:0]] <= $signed(req_tdata[102:71]);
         vz_mem[slot[VA_W-1:0]] <= $signed(req_tdata[134:103]);
         vw_mem[slot[VA_W-1:0]] <= $signed(req_tdata[166:135]);
      end
      vq_ff[0] <= vx_mem[va_ff];
      vq_ff[1] <= vy_mem[va_ff];
      vq_ff[2] <= vz_mem[va_ff];
      vq_ff[3] <= vw_mem[va_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 3'd3;
         count_ff  <= 7'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEGREE: degree_ff <= csr_wdata[2:0];
            CSR_COUNT:  count_ff  <= csr_wdata;
         endcase
      end
   end

   ncpe_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept && func == F_EVAL) begin
               deg_ff   <= deg_c;
               n_ff     <= vc_c - 1'b1;
               t_ff     <= $signed(req_tdata[198:167]);
               state_ff <= ST_HI;
            end
            ST_HI: state_ff <= ST_CHK_LO;
            ST_CHK_LO: begin
               if (t_ff >= kv) begin
                  span_ff  <= n_ff;
                  state_ff <= ST_BAS_INIT;
               end else state_ff <= ST_LO_CMP;
            end
            ST_LO_CMP: begin
               if (t_ff <= kv) begin
                  span_ff  <= deg_ff;
                  state_ff <= ST_BAS_INIT;
               end else begin
                  lo_ff    <= deg_ff;
                  hi_ff    <= n_ff + 1'b1;
                  state_ff <= ST_BS;
               end
            end
            ST_BS: begin
               if (hi_ff - lo_ff > IDX_W'(1)) state_ff <= ST_BS_CMP;
               else begin
                  span_ff  <= lo_ff;
                  state_ff <= ST_BAS_INIT;
               end
            end
            ST_BS_CMP: begin
               if (t_ff < kv) hi_ff <= mid;
               else lo_ff <= mid;
               state_ff <= ST_BS;
            end
            ST_BAS_INIT: begin
               bas_ff[0] <= 32'sh4000_0000;
               j_ff      <= IDX_W'(1);
               state_ff  <= ST_LR;
            end
            ST_LR: state_ff <= ST_LR2;
            ST_LR2: begin
               left_ff[j_ff[BI_W-1:0]] <= sat32(64'(t_ff) - 64'(kv));
               state_ff <= ST_LR3;
            end
            ST_LR3: begin
               right_ff[j_ff[BI_W-1:0]] <= sat32(64'(kv) - 64'(t_ff));
               r_ff     <= '0;
               saved_ff <= '0;
               state_ff <= ST_DEN;
            end
            ST_DEN: begin
               if (r_ff == j_ff) begin
                  bas_ff[j_ff[BI_W-1:0]] <= saved_ff;
                  j_ff <= j_ff + 1'b1;
                  state_ff <= (j_ff == deg_ff) ? ST_SA : ST_LR;
                  r_ff <= '0;
                  va_ff <= VA_W'(span_ff - deg_ff);
               end else if (den == '0) begin
                  bas_ff[r_ff[BI_W-1:0]] <= saved_ff;
                  saved_ff <= '0;
                  r_ff     <= r_ff + 1'b1;
               end else begin
                  div_req_ff.start <= 1'b1;
                  div_req_ff.num   <= NUM_W'({64'(bas_r), 16'h0} >>> 16 <<< 16);
                  div_req_ff.den   <= den;
                  state_ff         <= ST_DIVW;
               end
            end
            ST_DIVW: if (div_rsp.done) begin
               tmp_ff   <= sat32(64'(div_rsp.quot));
               state_ff <= ST_M1;
            end
            ST_M1: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_M2;
            end
            ST_M2: begin
               bas_ff[r_ff[BI_W-1:0]] <= sat32(64'(saved_ff) + rnd_shift(prod_ff, 16));
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_M3;
            end
            ST_M3: begin
               saved_ff <= sat32(rnd_shift(prod_ff, 16));
               r_ff     <= r_ff + 1'b1;
               state_ff <= ST_DEN;
            end
            ST_SA: begin
               if (r_ff == '0) for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
               j_ff     <= r_ff;
               state_ff <= ST_SB;
            end
            ST_SB: begin
               prod_ff  <= mul_a * mul_b;
               c_ff     <= '0;
               state_ff <= ST_SC;
            end
            ST_SC: begin
               acc_ff[c_ff] <= acc_ff[c_ff] + ACC_W'(rnd_shift(prod_ff, 30));
               if (c_ff != 2'd3) begin
                  prod_ff <= mul_a * mul_b;
                  c_ff    <= c_ff + 1'b1;
               end else if (r_ff == deg_ff) state_ff <= ST_FIN;
               else begin
                  r_ff     <= r_ff + 1'b1;
                  va_ff    <= va_ff + 1'b1;
                  state_ff <= ST_SA;
               end
            end
            ST_FIN: begin
               c_ff <= '0;
               if (acc_ff[3] == '0) begin
                  for (int i = 0; i < 3; i++) px_ff[i] <= sat32(64'(acc_ff[i]));
                  zw_ff        <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end else begin
                  zw_ff    <= 1'b0;
                  state_ff <= ST_FD;
               end
            end
            ST_FD: begin
               div_req_ff.start <= 1'b1;
               div_req_ff.num   <= {acc_ff[c_ff], 16'h0};
               div_req_ff.den   <= acc_ff[3];
               state_ff         <= ST_FDW;
            end
            ST_FDW: if (div_rsp.done) begin
               px_ff[c_ff] <= sat32(64'(div_rsp.quot));
               c_ff        <= c_ff + 1'b1;
               if (c_ff == 2'd2) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end else state_ff <= ST_FD;
            end
            ST_OUT: if (rsp_tready) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = zw_ff;
   assign rsp_tdata  = {px_ff[2], px_ff[1], px_ff[0]};

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result waits");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req_ff.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == F_EVAL) |=> !req_tready)
      else $error("evaluate request did not hold off the next request");

endmodule
